>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)

`define ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

>>> design/wecsf_pkg.sv
// Types and constants of the windowed event counter with store and forward.
package wecsf_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME     = 8'd1;

    localparam logic [31:0] WINDOW_RESET    = 32'd60000;
    localparam logic [31:0] DEAD_RESET      = 32'd2000;
    localparam logic [31:0] STAMP_THRESHOLD = 32'd100000;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    localparam logic KIND_LIVE   = 1'b0;
    localparam logic KIND_REPLAY = 1'b1;

    typedef struct packed {
        logic        sensor_level;
        logic        link_up;
        logic        send_ok;
        logic [31:0] wall_seconds;
    } in_item_t;

    typedef struct packed {
        logic        sample_kind;
        logic [15:0] event_count;
        logic [31:0] stamp_seconds;
        logic [31:0] lost_windows;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [31:0] stamp_seconds;
        logic [15:0] event_count;
    } store_entry_t;

    typedef struct packed {
        logic take_item;
        logic eval;
        logic live_emit;
        logic store;
        logic rd_first;
        logic rd_next;
        logic rep_emit;
    } cmd_t;

    typedef struct packed {
        logic win_close;
        logic send_go;
        logic q_empty;
        logic rep_last;
        logic out_free;
    } status_t;

endpackage

>>> design/wecsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wecsf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/wecsf_ctrl.sv
// Controller state machine sequencing one tick through evaluate, send, store and replay.
module wecsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wecsf_pkg::status_t sts,
    output wecsf_pkg::cmd_t    cmd
);

    import wecsf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LIVE,
        ST_STORE,
        ST_RD,
        ST_REP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.win_close)
                begin
                    state_next = sts.send_go ? ST_LIVE : ST_STORE;
                end
                else if (sts.send_go && !sts.q_empty)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIVE:
            begin
                if (sts.out_free)
                begin
                    cmd.live_emit = 1'b1;
                    state_next    = sts.q_empty ? ST_IDLE : ST_RD;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_REP;
            end
            ST_REP:
            begin
                if (sts.out_free)
                begin
                    cmd.rep_emit = 1'b1;
                    if (sts.rep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/wecsf_dp.sv
// Datapath: configuration, tick counters, window logic, sample queue and output register.
module wecsf_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wecsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    input  wecsf_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output wecsf_pkg::out_item_t                 out_data,
    input  wecsf_pkg::cmd_t                      cmd,
    output wecsf_pkg::status_t                   sts
);

    import wecsf_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int UW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int EW = $bits(store_entry_t);

    logic [31:0]   window_length_reg, window_length_next;
    logic [31:0]   dead_time_reg, dead_time_next;
    in_item_t      item_reg, item_next;
    logic [31:0]   tick_reg, tick_next;
    logic [31:0]   last_counted_reg, last_counted_next;
    logic [31:0]   window_start_reg, window_start_next;
    logic          prev_level_reg, prev_level_next;
    logic [15:0]   window_count_reg, window_count_next;
    logic [15:0]   close_count_reg, close_count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [UW-1:0] used_reg, used_next;
    logic [31:0]   dropped_reg, dropped_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    logic          edge_ok;
    logic [15:0]   inc_count;
    logic          win_close;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] slot_sum;
    logic [AW-1:0] slot;
    logic          q_full;
    logic          q_empty;
    logic          out_free;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    store_entry_t  ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_bits;
    store_entry_t  ram_rd_entry;

    assign cfg_ready = 1'b1;

    assign edge_ok   = item_reg.sensor_level && !prev_level_reg &&
                       ((tick_reg - last_counted_reg) >= dead_time_reg);
    assign inc_count = (edge_ok && (window_count_reg != COUNT_MAX)) ?
                       window_count_reg + 16'd1 : window_count_reg;
    assign win_close = (tick_reg - window_start_reg) >= window_length_reg;

    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign slot_sum = SW'(head_reg) + SW'(used_reg);
    assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                      AW'(slot_sum - SW'(QUEUE_DEPTH)) : AW'(slot_sum);
    assign q_full   = (used_reg == UW'(QUEUE_DEPTH));
    assign q_empty  = (used_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    assign sts.win_close = win_close;
    assign sts.send_go   = item_reg.link_up && item_reg.send_ok;
    assign sts.q_empty   = q_empty;
    assign sts.rep_last  = (used_reg == UW'(1));
    assign sts.out_free  = out_free;

    assign ram_wr_en                 = cmd.store;
    assign ram_wr_addr               = q_full ? head_reg : slot;
    assign ram_wr_data.stamp_seconds = (item_reg.wall_seconds > STAMP_THRESHOLD) ?
                                       item_reg.wall_seconds : 32'd0;
    assign ram_wr_data.event_count   = close_count_reg;
    assign ram_rd_en                 = cmd.rd_first || cmd.rd_next;
    assign ram_rd_addr               = cmd.rd_next ? head_inc : head_reg;
    assign ram_rd_entry              = store_entry_t'(ram_rd_bits);

    wecsf_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    always_comb
    begin
        window_length_next = window_length_reg;
        dead_time_next     = dead_time_reg;
        item_next          = item_reg;
        tick_next          = tick_reg;
        last_counted_next  = last_counted_reg;
        window_start_next  = window_start_reg;
        prev_level_next    = prev_level_reg;
        window_count_next  = window_count_reg;
        close_count_next   = close_count_reg;
        head_next          = head_reg;
        used_next          = used_reg;
        dropped_next       = dropped_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_length_next = cfg_data;
                REG_DEAD_TIME:     dead_time_next     = cfg_data;
                default:           ;
            endcase
        end

        if (cmd.take_item)
        begin
            item_next = in_data;
        end

        if (cmd.eval)
        begin
            prev_level_next = item_reg.sensor_level;
            if (edge_ok)
            begin
                last_counted_next = tick_reg;
            end
            if (win_close)
            begin
                close_count_next  = inc_count;
                window_count_next = '0;
                window_start_next = tick_reg;
            end
            else
            begin
                window_count_next = inc_count;
            end
            tick_next = tick_reg + 32'd1;
        end

        if (cmd.live_emit)
        begin
            out_valid_next              = 1'b1;
            out_data_next.sample_kind   = KIND_LIVE;
            out_data_next.event_count   = close_count_reg;
            out_data_next.stamp_seconds = '0;
            out_data_next.lost_windows  = dropped_reg;
            out_data_next.last_of_run   = q_empty;
        end

        if (cmd.store)
        begin
            if (q_full)
            begin
                dropped_next = dropped_reg + 32'd1;
                head_next    = head_inc;
            end
            else
            begin
                used_next = used_reg + UW'(1);
            end
        end

        if (cmd.rep_emit)
        begin
            out_valid_next              = 1'b1;
            out_data_next.sample_kind   = KIND_REPLAY;
            out_data_next.event_count   = ram_rd_entry.event_count;
            out_data_next.stamp_seconds = ram_rd_entry.stamp_seconds;
            out_data_next.lost_windows  = dropped_reg;
            out_data_next.last_of_run   = (used_reg == UW'(1));
            head_next                   = head_inc;
            used_next                   = used_reg - UW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            dead_time_reg     <= DEAD_RESET;
            tick_reg          <= '0;
            last_counted_reg  <= '0;
            window_start_reg  <= '0;
            prev_level_reg    <= 1'b0;
            window_count_reg  <= '0;
            head_reg          <= '0;
            used_reg          <= '0;
            dropped_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            dead_time_reg     <= dead_time_next;
            tick_reg          <= tick_next;
            last_counted_reg  <= last_counted_next;
            window_start_reg  <= window_start_next;
            prev_level_reg    <= prev_level_next;
            window_count_reg  <= window_count_next;
            head_reg          <= head_next;
            used_reg          <= used_next;
            dropped_reg       <= dropped_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        close_count_reg <= close_count_next;
        out_data_reg    <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/windowed_event_counter_store_forward.sv
// Top level: one tick per transaction, dead-time edge counter with a store-and-forward queue.
// A tick with no result is accepted and evaluated; a store or a live send adds a state of its own.
// Replay adds a state for the first RAM read, then reads the queued samples in turn through the
// single read port whenever the output is free. Results leave through an output register, so
// the next tick is taken while one waits. Asynchronous reset clears counters, queue pointers
// and out_valid, sets configuration defaults; item, close count, out data and RAM are not cleared.
module windowed_event_counter_store_forward #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wecsf_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wecsf_pkg::out_item_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wecsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    import wecsf_pkg::*;

`include "assert_macros.svh"

    cmd_t    cmd;
    status_t sts;

    wecsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wecsf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    `ASSERT_NEXT(a_accept_then_eval, clk, rst_n, in_valid && in_ready, cmd.eval)
    `ASSERT_IMPLIES(a_replay_not_empty, clk, rst_n, cmd.rep_emit, !sts.q_empty)
    `ASSERT_IMPLIES(a_emit_into_free_slot, clk, rst_n, cmd.live_emit || cmd.rep_emit, sts.out_free)
    `ASSERT_IMPLIES(a_store_only_refused, clk, rst_n, cmd.store, !sts.send_go)

endmodule
